@@ hdl/irans_pkg.sv @@
package irans_pkg;

	localparam int unsigned PRECISION_BITS_DEF = 12;
	localparam int unsigned LOWER_BOUND_DEF    = 4096;
	localparam int unsigned ALPHABET_SIZE_DEF  = 256;

	localparam int unsigned FREQ_W  = 13;
	localparam int unsigned CUM_W   = 12;
	localparam int unsigned STATE_W = 32;
	localparam int unsigned WORD_W  = 16;

	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_ENCODE = 2'd1;
	localparam logic [1:0] OP_FINISH = 2'd2;

	localparam logic [1:0] KIND_WORD  = 2'd0;
	localparam logic [1:0] KIND_FINAL = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [7:0]        symbol;
		logic [FREQ_W-1:0] sym_freq;
		logic [CUM_W-1:0]  sym_cum;
		logic              lane;
	} cmd_item_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [STATE_W-1:0] value;
		logic               out_lane;
		logic               last;
	} rsp_item_t;

	typedef struct packed {
		logic [FREQ_W-1:0] freq;
		logic [CUM_W-1:0]  cum;
	} tbl_entry_t;

	typedef struct packed {
		logic                  start;
		logic [STATE_W-1:0]    dividend;
		logic [FREQ_W-1:0]     divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [WORD_W-1:0] quot;
		logic [FREQ_W-1:0] rem;
	} div_rsp_t;

endpackage

@@ hdl/irans_table.sv @@
module irans_table #(
	parameter int unsigned ALPHABET_SIZE = irans_pkg::ALPHABET_SIZE_DEF
) (
	input  logic                   clk,
	input  logic                   wr_en,
	input  logic [7:0]             wr_addr,
	input  irans_pkg::tbl_entry_t  wr_data,
	input  logic                   rd_en,
	input  logic [7:0]             rd_addr,
	output irans_pkg::tbl_entry_t  rd_data
);
	import irans_pkg::*;

	localparam int unsigned IDX_W = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;

	tbl_entry_t mem [ALPHABET_SIZE];
	tbl_entry_t rd_data_q;

	// caller guarantees addresses are inside the alphabet
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr[IDX_W-1:0]] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr[IDX_W-1:0]];
		end
	end

	assign rd_data = rd_data_q;
endmodule

@@ hdl/irans_div.sv @@
module irans_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  irans_pkg::div_req_t  req,
	output irans_pkg::div_rsp_t  rsp
);
	import irans_pkg::*;

	localparam int unsigned CNT_W = $clog2(WORD_W);

	logic [FREQ_W-1:0] rem_q;
	logic [WORD_W-1:0] quot_q;
	logic [FREQ_W-1:0] dvsr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [FREQ_W:0]   trial;
	logic              fits;

	// restoring step: bring down the next dividend bit, quotient bit shifts in
	assign trial = {rem_q, quot_q[WORD_W-1]};
	assign fits  = trial >= {1'b0, dvsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(WORD_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			// dividend < divisor << 16, so the upper half fits the remainder
			rem_q  <= req.dividend[WORD_W +: FREQ_W];
			quot_q <= req.dividend[WORD_W-1:0];
			dvsr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q  <= fits ? FREQ_W'(trial - {1'b0, dvsr_q}) : trial[FREQ_W-1:0];
			quot_q <= {quot_q[WORD_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
	assign rsp.rem  = rem_q;
endmodule

@@ hdl/interleaved_rans_encoder_unit.sv @@
// encode: a table lookup, then sixteen steps of the restoring divider, then the state update;
// a renormalization word waits for a free output before the division starts
// load and unused opcodes give no result, a zero frequency encode gives an error result,
// finish gives both lane states as final results, even lane first, and a waiting result holds those
// reset clears the handshake and both lane states to the lower bound
// the frequency table holds nothing defined until loaded
module interleaved_rans_encoder_unit #(
	parameter int unsigned PRECISION_BITS = irans_pkg::PRECISION_BITS_DEF,
	parameter int unsigned LOWER_BOUND    = irans_pkg::LOWER_BOUND_DEF,
	parameter int unsigned ALPHABET_SIZE  = irans_pkg::ALPHABET_SIZE_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_stall,
	input  irans_pkg::cmd_item_t  cmd,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output irans_pkg::rsp_item_t  rsp
);
	import irans_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_LOOK = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_FIN2 = 4'b1000
	} fsm_t;

	fsm_t               state_q;
	logic [STATE_W-1:0] lane_st_q [2];
	logic               lane_q;
	logic               in_range_q;
	logic               fin1_q;
	logic               out_valid_q;
	rsp_item_t          out_q;

	logic               cmd_xfer;
	logic               out_free;
	logic               sym_ok;
	tbl_entry_t         tbl_wr;
	tbl_entry_t         tbl_rd;
	logic [FREQ_W-1:0]  freq_eff;
	logic [STATE_W-1:0] x_cur;
	logic               renorm;
	div_req_t           div_req;
	div_rsp_t           div_rsp;
	logic [STATE_W-1:0] new_state;

	assign cmd_stall = (state_q != ST_IDLE) || fin1_q;
	assign cmd_xfer  = cmd_valid && !cmd_stall;
	assign out_free  = !out_valid_q || !rsp_stall;
	assign sym_ok    = {1'b0, cmd.symbol} < 9'(ALPHABET_SIZE);

	assign tbl_wr.freq = cmd.sym_freq;
	assign tbl_wr.cum  = cmd.sym_cum;

	irans_table #(
		.ALPHABET_SIZE(ALPHABET_SIZE)
	) u_table (
		.clk     (clk),
		.wr_en   (cmd_xfer && cmd.opcode == OP_LOAD && sym_ok),
		.wr_addr (cmd.symbol),
		.wr_data (tbl_wr),
		.rd_en   (cmd_xfer && cmd.opcode == OP_ENCODE),
		.rd_addr (cmd.symbol),
		.rd_data (tbl_rd)
	);

	// symbols beyond the alphabet encode as zero frequency
	assign freq_eff = in_range_q ? tbl_rd.freq : '0;
	assign x_cur    = lane_st_q[lane_q];
	assign renorm   = x_cur >= {3'b000, freq_eff, 16'h0000};

	always_comb begin
		div_req.start    = (state_q == ST_LOOK) && (freq_eff != '0) && (!renorm || out_free);
		div_req.dividend = renorm ? {16'h0000, x_cur[STATE_W-1:WORD_W]} : x_cur;
		div_req.divisor  = freq_eff;
	end

	irans_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign new_state = (STATE_W'(div_rsp.quot) << PRECISION_BITS)
		+ STATE_W'(tbl_rd.cum) + STATE_W'(div_rsp.rem);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			fin1_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			lane_st_q[0] <= STATE_W'(LOWER_BOUND);
			lane_st_q[1] <= STATE_W'(LOWER_BOUND);
		end else begin
			if (out_valid_q && !rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (fin1_q) begin
						// first final state, even lane
						if (out_free) begin
							out_valid_q  <= 1'b1;
							fin1_q       <= 1'b0;
							lane_st_q[0] <= STATE_W'(LOWER_BOUND);
							state_q      <= ST_FIN2;
						end
					end else if (cmd_xfer) begin
						if (cmd.opcode == OP_ENCODE) begin
							state_q <= ST_LOOK;
						end else if (cmd.opcode == OP_FINISH) begin
							fin1_q <= 1'b1;
						end
					end
				end
				ST_LOOK: begin
					if (out_free && (freq_eff == '0 || renorm)) begin
						out_valid_q <= 1'b1;
					end
					if (freq_eff == '0) begin
						if (out_free) begin
							state_q <= ST_IDLE;
						end
					end else if (div_req.start) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						lane_st_q[lane_q] <= new_state;
						state_q           <= ST_IDLE;
					end
				end
				ST_FIN2: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						lane_st_q[1] <= STATE_W'(LOWER_BOUND);
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_xfer && cmd.opcode == OP_ENCODE) begin
			lane_q     <= cmd.lane;
			in_range_q <= sym_ok;
		end
		if (out_free) begin
			if (state_q == ST_IDLE && fin1_q) begin
				out_q.kind     <= KIND_FINAL;
				out_q.value    <= lane_st_q[0];
				out_q.out_lane <= 1'b0;
				out_q.last     <= 1'b0;
			end else if (state_q == ST_FIN2) begin
				out_q.kind     <= KIND_FINAL;
				out_q.value    <= lane_st_q[1];
				out_q.out_lane <= 1'b1;
				out_q.last     <= 1'b1;
			end else if (state_q == ST_LOOK && freq_eff == '0) begin
				out_q.kind     <= KIND_ERROR;
				out_q.value    <= '0;
				out_q.out_lane <= lane_q;
				out_q.last     <= 1'b0;
			end else if (state_q == ST_LOOK && renorm) begin
				out_q.kind     <= KIND_WORD;
				out_q.value    <= {16'h0000, x_cur[WORD_W-1:0]};
				out_q.out_lane <= lane_q;
				out_q.last     <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;
endmodule
